@@ hw/rtl/sms_pkg.sv @@
// Shared types, sizes and the exponent table for the softmax regression block.
package sms_pkg;

	localparam int NUM_CLASSES  = 10;
	localparam int NUM_FEATURES = 784;

	localparam int IDX_W  = $clog2(NUM_FEATURES + 1);
	localparam int ADDR_W = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
	localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int W_W    = 32;
	localparam int ACC_W  = 40;
	localparam int SLOT_W = 41;
	localparam int S_W    = 34;
	localparam int E_W    = 17;
	localparam int DEN_W  = $clog2(NUM_CLASSES * 65536 + 1);
	localparam int LOG2E_Q24 = 24204406;

	typedef struct packed {
		logic       op;
		logic [7:0] feature;
		logic [3:0] label;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic [3:0] predicted_class;
		logic       correct;
	} res_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic              re;
		logic              we;
		logic              clr;
		logic              acc;
		logic              logit_ld;
		logic              shift;
		logic              upd_b;
		logic [7:0]        feat;
		logic [7:0]        x;
	} cell_ctl_t;

	// 2^(-i/16) in Q1.16, rounded
	function automatic logic [E_W-1:0] exp_lut(input logic [3:0] i);
		logic [E_W-1:0] v;
		case (i)
			4'd0:  v = 17'd65536;
			4'd1:  v = 17'd62757;
			4'd2:  v = 17'd60097;
			4'd3:  v = 17'd57549;
			4'd4:  v = 17'd55109;
			4'd5:  v = 17'd52773;
			4'd6:  v = 17'd50535;
			4'd7:  v = 17'd48393;
			4'd8:  v = 17'd46341;
			4'd9:  v = 17'd44376;
			4'd10: v = 17'd42495;
			4'd11: v = 17'd40693;
			4'd12: v = 17'd38968;
			4'd13: v = 17'd37316;
			4'd14: v = 17'd35734;
			default: v = 17'd34219;
		endcase
		return v;
	endfunction

endpackage

@@ hw/rtl/sms_cell.sv @@
// One class cell: weight row memory, bias, logit accumulator and chain slot.
module sms_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sms_pkg::cell_ctl_t            ctl,
	input  logic [sms_pkg::SLOT_W-1:0]    shift_in,
	output logic [sms_pkg::SLOT_W-1:0]    slot
);

	logic signed [sms_pkg::W_W-1:0] w_mem [sms_pkg::NUM_FEATURES];
	logic signed [sms_pkg::W_W-1:0] rd_q;
	logic signed [sms_pkg::W_W-1:0] bias_q;
	logic signed [sms_pkg::ACC_W-1:0] acc_q;
	logic [sms_pkg::SLOT_W-1:0] slot_q;

	logic signed [40:0] prod;
	logic signed [40:0] acc_sum;
	logic signed [40:0] logit_sum;
	logic signed [sms_pkg::ACC_W-1:0] acc_sat, logit_sat;
	logic signed [sms_pkg::S_W-1:0] s;
	logic signed [42:0] dprod;
	logic signed [42:0] drnd;
	logic signed [33:0] wdiff;
	logic signed [sms_pkg::W_W-1:0] wnew, wdata;
	logic signed [34:0] brnd;
	logic signed [33:0] bdiff;
	logic signed [sms_pkg::W_W-1:0] bnew;

	localparam logic signed [40:0] ACC_MAX = {2'b00, {39{1'b1}}};
	localparam logic signed [40:0] ACC_MIN = {2'b11, {39{1'b0}}};
	localparam logic signed [33:0] W_MAX = {3'b000, {31{1'b1}}};
	localparam logic signed [33:0] W_MIN = {3'b111, {31{1'b0}}};

	assign s = $signed(slot_q[sms_pkg::S_W-1:0]);

	always_comb begin
		prod = 41'(rd_q) * 41'($signed({1'b0, ctl.feat}));
		acc_sum = 41'(acc_q) + 41'($signed(prod[40:8]));
		if (acc_sum > ACC_MAX) acc_sat = ACC_MAX[39:0];
		else if (acc_sum < ACC_MIN) acc_sat = ACC_MIN[39:0];
		else acc_sat = acc_sum[39:0];

		logit_sum = 41'(acc_q) + 41'(bias_q);
		if (logit_sum > ACC_MAX) logit_sat = ACC_MAX[39:0];
		else if (logit_sum < ACC_MIN) logit_sat = ACC_MIN[39:0];
		else logit_sat = logit_sum[39:0];

		dprod = 43'(s) * 43'($signed({1'b0, ctl.x}));
		drnd = dprod + 43'sd32768;
		wdiff = 34'(rd_q) - 34'($signed(drnd[42:16]));
		if (wdiff > W_MAX) wnew = W_MAX[31:0];
		else if (wdiff < W_MIN) wnew = W_MIN[31:0];
		else wnew = wdiff[31:0];
		wdata = ctl.clr ? '0 : wnew;

		brnd = 35'(s) + 35'sd128;
		bdiff = 34'(bias_q) - 34'($signed(brnd[34:8]));
		if (bdiff > W_MAX) bnew = W_MAX[31:0];
		else if (bdiff < W_MIN) bnew = W_MIN[31:0];
		else bnew = bdiff[31:0];
	end

	always_ff @(posedge clk) begin
		if (ctl.we) w_mem[ctl.addr] <= wdata;
		if (ctl.re) rd_q <= w_mem[ctl.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			bias_q <= '0;
		end else begin
			if (ctl.acc) acc_q <= acc_sat;
			else if (ctl.logit_ld) acc_q <= '0;
			if (ctl.upd_b) bias_q <= bnew;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.logit_ld) slot_q <= 41'(logit_sat);
		else if (ctl.shift) slot_q <= shift_in;
	end

	assign slot = slot_q;

endmodule

@@ hw/rtl/softmax_regression_sgd.sv @@
// Top level: softmax regression classifier with on-line SGD training.
//
// Usage:
//  - Feed one feature per item on cmd while start is high and busy is low.
//    The item with cmd.last set closes the sample; its op and label count.
//  - Each feature is accepted in IDLE, then multiply-accumulated in ACC in
//    all class cells at once from the registered weight read, busy high.
//  - On the last item the logits load into the cell chain and rotate past a
//    comparator: done pulses for one cycle with res after every logit has
//    passed (LOGIT, AMAX, RES). The receiver cannot stall; take res on done.
//  - With op set, training follows before busy drops: the exponents per
//    class (EXPA, EXPB), the bit-serial divide and step per class (DIVS,
//    DIV, STEP), the bias update, then a read and a write per stored feature
//    for the weight writeback (all rows in parallel).
//  - learning_rate is written through cfg_valid/cfg_data; cfg_ready is
//    always high. Write it only while the block is idle.
//  - After reset the weight memories are cleared one address a cycle, so
//    busy stays high until all NUM_FEATURES addresses are clear. Biases and
//    accumulators clear at once; learning_rate resets to 66.
module softmax_regression_sgd (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  sms_pkg::cmd_t     cmd,
	output logic              done,
	output sms_pkg::res_t     res,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [15:0]       cfg_data
);

	localparam logic [3:0] ST_CLR   = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_ACC   = 4'd2;
	localparam logic [3:0] ST_LOGIT = 4'd3;
	localparam logic [3:0] ST_AMAX  = 4'd4;
	localparam logic [3:0] ST_RES   = 4'd5;
	localparam logic [3:0] ST_EXPA  = 4'd6;
	localparam logic [3:0] ST_EXPB  = 4'd7;
	localparam logic [3:0] ST_DIVS  = 4'd8;
	localparam logic [3:0] ST_DIV   = 4'd9;
	localparam logic [3:0] ST_STEP  = 4'd10;
	localparam logic [3:0] ST_UPB   = 4'd11;
	localparam logic [3:0] ST_UPR   = 4'd12;
	localparam logic [3:0] ST_UPW   = 4'd13;
	localparam logic [3:0] ST_FIN   = 4'd14;

	localparam int NC = sms_pkg::NUM_CLASSES;
	localparam int NF = sms_pkg::NUM_FEATURES;
	localparam logic [sms_pkg::CLS_W-1:0] CLS_LAST = sms_pkg::CLS_W'(NC - 1);
	localparam logic [sms_pkg::IDX_W-1:0] IDX_NF = sms_pkg::IDX_W'(NF);
	localparam logic [40:0] D_CLAMP = 41'(64'd17 << 24);

	logic [3:0] state_q;
	logic [sms_pkg::IDX_W-1:0] idx_q;
	logic [sms_pkg::IDX_W-1:0] addr_q;
	logic [sms_pkg::CLS_W-1:0] cls_q;
	logic [5:0] bit_q;
	logic [15:0] lr_q;
	logic [7:0] feat_q, fx_q;
	logic op_q, last_q, acc_v_q;
	logic [3:0] label_q;
	logic signed [sms_pkg::ACC_W-1:0] best_q;
	logic [sms_pkg::CLS_W-1:0] best_idx_q;
	logic [29:0] t_q;
	logic [sms_pkg::DEN_W-1:0] den_q, rem_q;
	logic [32:0] n_q;
	logic done_q;

	logic [7:0] fbuf [NF];

	sms_pkg::cell_ctl_t ctl;
	logic [sms_pkg::SLOT_W-1:0] slot [NC];
	logic [sms_pkg::SLOT_W-1:0] inject;

	logic accept;
	logic signed [sms_pkg::ACC_W-1:0] head;
	logic [40:0] d, dc;
	logic [53:0] tprod;
	logic [5:0] k;
	logic [sms_pkg::E_W-1:0] e;
	logic [sms_pkg::DEN_W:0] r2;
	logic ge;
	logic signed [17:0] g;
	logic signed [sms_pkg::S_W-1:0] s;

	assign accept = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign head = $signed(slot[0][sms_pkg::ACC_W-1:0]);

	// exponent path: d = max - logit, clamped, times log2(e)
	always_comb begin
		d = 41'(best_q) - 41'(head);
		dc = (d > D_CLAMP) ? D_CLAMP : d;
		tprod = 54'(dc[28:0]) * 54'(sms_pkg::LOG2E_Q24);
		k = t_q[29:24];
		e = (k > 6'd16) ? '0 : (sms_pkg::exp_lut(t_q[23:20]) >> k);
	end

	// restoring divide step and SGD step
	always_comb begin
		r2 = {rem_q, n_q[32]};
		ge = (r2 >= {1'b0, den_q});
		g = $signed({1'b0, n_q[16:0]})
			- ((32'(cls_q) == 32'(label_q)) ? 18'sd65536 : 18'sd0);
		s = sms_pkg::S_W'($signed({1'b0, lr_q})) * sms_pkg::S_W'(g);
	end

	always_comb begin
		ctl = '0;
		ctl.addr = addr_q[sms_pkg::ADDR_W-1:0];
		ctl.feat = feat_q;
		ctl.x = fx_q;
		inject = slot[0];
		unique case (state_q)
			ST_CLR: begin
				ctl.we = 1'b1;
				ctl.clr = 1'b1;
			end
			ST_IDLE: begin
				ctl.addr = idx_q[sms_pkg::ADDR_W-1:0];
				ctl.re = start && (idx_q < IDX_NF);
			end
			ST_ACC: ctl.acc = acc_v_q;
			ST_LOGIT: ctl.logit_ld = 1'b1;
			ST_AMAX: ctl.shift = 1'b1;
			ST_EXPB: begin
				ctl.shift = 1'b1;
				inject = 41'(e);
			end
			ST_STEP: begin
				ctl.shift = 1'b1;
				inject = 41'(s);
			end
			ST_UPB: ctl.upd_b = 1'b1;
			ST_UPR: ctl.re = 1'b1;
			ST_UPW: ctl.we = 1'b1;
			default: ;
		endcase
	end

	// the chain: each cell hands its slot toward cell 0, inject (cell 0's slot by default) feeds the tail
	for (genvar i = 0; i < NC; i++) begin : g_cell
		logic [sms_pkg::SLOT_W-1:0] nxt;
		if (i == NC - 1) begin : g_tail
			assign nxt = inject;
		end else begin : g_mid
			assign nxt = slot[i+1];
		end
		sms_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.shift_in (nxt),
			.slot     (slot[i])
		);
	end

	// feature buffer
	always_ff @(posedge clk) begin
		if (accept && (idx_q < IDX_NF)) fbuf[idx_q[sms_pkg::ADDR_W-1:0]] <= cmd.feature;
		if (state_q == ST_UPR) fx_q <= fbuf[addr_q[sms_pkg::ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q <= 16'd66;
		end else if (cfg_valid) begin
			lr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			idx_q   <= '0;
			addr_q  <= '0;
			cls_q   <= '0;
			bit_q   <= '0;
			acc_v_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == IDX_NF - 1'b1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) begin
						acc_v_q <= (idx_q < IDX_NF);
						if (idx_q < IDX_NF) idx_q <= idx_q + 1'b1;
						state_q <= ST_ACC;
					end
				end
				ST_ACC: state_q <= last_q ? ST_LOGIT : ST_IDLE;
				ST_LOGIT: begin
					cls_q <= '0;
					state_q <= ST_AMAX;
				end
				ST_AMAX: begin
					cls_q <= cls_q + 1'b1;
					if (cls_q == CLS_LAST) state_q <= ST_RES;
				end
				ST_RES: begin
					done_q <= 1'b1;
					cls_q <= '0;
					state_q <= op_q ? ST_EXPA : ST_FIN;
				end
				ST_EXPA: state_q <= ST_EXPB;
				ST_EXPB: begin
					if (cls_q == CLS_LAST) begin
						cls_q <= '0;
						state_q <= ST_DIVS;
					end else begin
						cls_q <= cls_q + 1'b1;
						state_q <= ST_EXPA;
					end
				end
				ST_DIVS: begin
					bit_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					bit_q <= bit_q + 1'b1;
					if (bit_q == 6'd32) state_q <= ST_STEP;
				end
				ST_STEP: begin
					if (cls_q == CLS_LAST) begin
						state_q <= ST_UPB;
					end else begin
						cls_q <= cls_q + 1'b1;
						state_q <= ST_DIVS;
					end
				end
				ST_UPB: begin
					addr_q <= '0;
					state_q <= (idx_q == '0) ? ST_FIN : ST_UPR;
				end
				ST_UPR: state_q <= ST_UPW;
				ST_UPW: begin
					addr_q <= addr_q + 1'b1;
					state_q <= (addr_q == idx_q - 1'b1) ? ST_FIN : ST_UPR;
				end
				ST_FIN: begin
					idx_q <= '0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			feat_q  <= cmd.feature;
			op_q    <= cmd.op;
			label_q <= cmd.label;
			last_q  <= cmd.last;
		end
		if (state_q == ST_AMAX) begin
			if (cls_q == '0 || head > best_q) begin
				best_q <= head;
				best_idx_q <= cls_q;
			end
		end
		if (state_q == ST_RES) den_q <= '0;
		if (state_q == ST_EXPA) t_q <= tprod[53:24];
		if (state_q == ST_EXPB) den_q <= den_q + sms_pkg::DEN_W'(e);
		if (state_q == ST_DIVS) begin
			n_q <= {slot[0][sms_pkg::E_W-1:0], 16'd0};
			rem_q <= '0;
		end
		if (state_q == ST_DIV) begin
			rem_q <= ge ? sms_pkg::DEN_W'(r2 - {1'b0, den_q}) : r2[sms_pkg::DEN_W-1:0];
			n_q <= {n_q[31:0], ge};
		end
	end

	assign done = done_q;
	assign res.predicted_class = 4'(best_idx_q);
	assign res.correct = (32'(best_idx_q) == 32'(label_q));

endmodule
